// ----- src/ab565_pkg.sv -----
// Shared types and constants for the ARGB-over-RGB565 blender.
`timescale 1ns / 1ps
`default_nettype none

package ab565_pkg;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [1:0] {
        MODE_COPY,
        MODE_SKIP,
        MODE_BLEND
    } mode_t;

    typedef struct packed {
        logic [31:0] src_argb;
        logic [15:0] dst_pixel;
        logic        process_alpha;
    } ab565_in_t;

    typedef struct packed {
        logic [15:0] out_pixel;
        logic        write_enable;
    } ab565_out_t;

    // Decoded beat: operands ready for the multipliers.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] copy_pix;
        logic [7:0]  alpha;
        logic [7:0]  inv_alpha;
        logic [7:0]  sr;
        logic [7:0]  sg;
        logic [7:0]  sb;
        logic [7:0]  dr;
        logic [7:0]  dg;
        logic [7:0]  db;
    } ab565_dec_t;

    // Product beat: source and destination terms per channel.
    typedef struct packed {
        mode_t       mode;
        logic [15:0] copy_pix;
        logic [15:0] ps_r;
        logic [15:0] ps_g;
        logic [15:0] ps_b;
        logic [15:0] pd_r;
        logic [15:0] pd_g;
        logic [15:0] pd_b;
    } ab565_prod_t;

endpackage

`default_nettype wire

// ----- src/ab565_decode.sv -----
// Stage 1: classify the beat and widen the destination to 8 bits per channel.
`timescale 1ns / 1ps
`default_nettype none

module ab565_decode (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    input  wire ab565_pkg::ab565_in_t item,
    output logic                   dec_valid,
    output ab565_pkg::ab565_dec_t  dec
);

    logic                  valid_reg;
    ab565_pkg::ab565_dec_t dec_reg;
    ab565_pkg::ab565_dec_t dec_next;
    logic [7:0]            alpha;
    logic [4:0]            r5;
    logic [5:0]            g6;
    logic [4:0]            b5;

    always_comb
    begin
        alpha = item.src_argb[31:24];
        r5    = item.dst_pixel[15:11];
        g6    = item.dst_pixel[10:5];
        b5    = item.dst_pixel[4:0];

        if (!item.process_alpha || alpha == ab565_pkg::ALPHA_OPAQUE)
        begin
            dec_next.mode = ab565_pkg::MODE_COPY;
        end
        else if (alpha == ab565_pkg::ALPHA_CLEAR)
        begin
            dec_next.mode = ab565_pkg::MODE_SKIP;
        end
        else
        begin
            dec_next.mode = ab565_pkg::MODE_BLEND;
        end

        dec_next.copy_pix  = {item.src_argb[23:19], item.src_argb[15:10], item.src_argb[7:3]};
        dec_next.alpha     = alpha;
        dec_next.inv_alpha = ab565_pkg::ALPHA_OPAQUE - alpha;
        dec_next.sr        = item.src_argb[23:16];
        dec_next.sg        = item.src_argb[15:8];
        dec_next.sb        = item.src_argb[7:0];
        // replicate high bits into the vacated low bits
        dec_next.dr        = {r5, r5[4:2]};
        dec_next.dg        = {g6, g6[5:4]};
        dec_next.db        = {b5, b5[4:2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

`default_nettype wire

// ----- src/ab565_mul.sv -----
// Stage 2: the six 8x8 channel products.
`timescale 1ns / 1ps
`default_nettype none

module ab565_mul (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     dec_valid,
    input  wire ab565_pkg::ab565_dec_t dec,
    output logic                    prod_valid,
    output ab565_pkg::ab565_prod_t  prod
);

    logic                   valid_reg;
    ab565_pkg::ab565_prod_t prod_reg;
    ab565_pkg::ab565_prod_t prod_next;

    always_comb
    begin
        prod_next.mode     = dec.mode;
        prod_next.copy_pix = dec.copy_pix;
        prod_next.ps_r     = dec.sr * dec.alpha;
        prod_next.ps_g     = dec.sg * dec.alpha;
        prod_next.ps_b     = dec.sb * dec.alpha;
        prod_next.pd_r     = dec.dr * dec.inv_alpha;
        prod_next.pd_g     = dec.dg * dec.inv_alpha;
        prod_next.pd_b     = dec.db * dec.inv_alpha;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule

`default_nettype wire

// ----- src/ab565_pack.sv -----
// Stage 3: for a blend, divide by 255, sum per channel and pack to RGB565; else pass the copy pixel or drop the write.
`timescale 1ns / 1ps
`default_nettype none

module ab565_pack (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     prod_valid,
    input  wire ab565_pkg::ab565_prod_t prod,
    output logic                    done,
    output ab565_pkg::ab565_out_t   result
);

    logic                  valid_reg;
    ab565_pkg::ab565_out_t result_reg;
    ab565_pkg::ab565_out_t result_next;
    logic [7:0]            ch_r;
    logic [7:0]            ch_g;
    logic [7:0]            ch_b;

    // floor(x / 255), exact for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        begin
            t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
            return t[15:8];
        end
    endfunction

    always_comb
    begin
        ch_r = div255(prod.ps_r) + div255(prod.pd_r);
        ch_g = div255(prod.ps_g) + div255(prod.pd_g);
        ch_b = div255(prod.ps_b) + div255(prod.pd_b);

        case (prod.mode)
            ab565_pkg::MODE_COPY:
            begin
                result_next.out_pixel    = prod.copy_pix;
                result_next.write_enable = 1'b1;
            end
            ab565_pkg::MODE_BLEND:
            begin
                result_next.out_pixel    = {ch_r[7:3], ch_g[7:2], ch_b[7:3]};
                result_next.write_enable = 1'b1;
            end
            default:
            begin
                // drop the write for a fully transparent source
                result_next.out_pixel    = 16'd0;
                result_next.write_enable = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- src/argb_over_rgb565_blend.sv -----
// A beat accepted on start passes the decode, multiply and divide-and-pack registers in that order
// and then is on result, with done high, for the receiver to take.
// Throughput: one pixel per clock; busy stays low, so start may be held high every cycle.
// Three register stages (decode, multiply, divide-and-pack) carry a valid bit each.
// The receiver cannot stall, so the pipeline always advances.
// Reset (rst_n, async, active low) clears the valid bits; no result is shown until a new beat.
`timescale 1ns / 1ps
`default_nettype none

module argb_over_rgb565_blend (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    output logic                   busy,
    input  wire ab565_pkg::ab565_in_t item,
    output logic                   done,
    output ab565_pkg::ab565_out_t  result
);

    logic                   dec_valid;
    ab565_pkg::ab565_dec_t  dec;
    logic                   prod_valid;
    ab565_pkg::ab565_prod_t prod;

    // the pipeline never stalls
    assign busy = 1'b0;

    ab565_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .item      (item),
        .dec_valid (dec_valid),
        .dec       (dec)
    );

    ab565_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .dec_valid  (dec_valid),
        .dec        (dec),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    ab565_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .done       (done),
        .result     (result)
    );

`ifndef SYNTHESIS
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted beat did not produce a result");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##3 !done)
        else $error("result without an accepted beat");

    a_skip_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.write_enable) |-> result.out_pixel == 16'd0)
        else $error("skipped write carries a nonzero pixel");

    a_opaque_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !item.process_alpha) |-> ##3 result.write_enable)
        else $error("opaque copy lost its write enable");
`endif

endmodule

`default_nettype wire
